/* sv/signed_radix_digit_emitter_core_macros.svh */
// ---------------------------------------------------------------------------
// signed radix digit emitter assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef SIGNED_RADIX_DIGIT_EMITTER_CORE_MACROS_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_CORE_MACROS_SVH

// same-cycle implication
`define SRDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srde assertion failed");

// next-cycle implication
`define SRDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srde assertion failed");

`endif

/* sv/srde_pkg.sv */
// ---------------------------------------------------------------------------
// srde_pkg
// types and constants shared by the signed radix digit emitter
// ---------------------------------------------------------------------------
package srde_pkg;

  localparam int IN_W       = 32;
  localparam int CHAR_W     = 8;
  localparam int BASE_W     = 5;
  localparam int ALPHA_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_SYMS   = 16;
  localparam int SYM_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic chk_step;
    logic div_step;
    logic rd;
    logic emit_sign;
    logic emit_digit;
  } srde_cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic chk_done;
    logic div_last;
    logic quo_zero;
    logic neg;
    logic cnt_zero;
    logic out_free;
  } srde_sts_t;

  function automatic logic [CHAR_W-1:0] sym_at(input logic [2*ALPHA_W-1:0] alpha,
                                               input logic [SYM_IDX_W-1:0] idx);
    sym_at = alpha[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

/* sv/srde_if.sv */
// ---------------------------------------------------------------------------
// srde channel interfaces
// valid/ready channels for input values and output characters
// ---------------------------------------------------------------------------
interface srde_in_if import srde_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srde_out_if import srde_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

/* sv/srde_ram.sv */
// ---------------------------------------------------------------------------
// srde_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module srde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/srde_ctrl.sv */
// ---------------------------------------------------------------------------
// srde_ctrl
// sequencer: accept, alphabet check, digit division, character emission
// ---------------------------------------------------------------------------
module srde_ctrl import srde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  srde_sts_t sts,
  output srde_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_DIVIDE = 6'b000100,
    S_SIGN   = 6'b001000,
    S_READ   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.chk_fail) begin
          state_nxt = S_IDLE;
        end else if (sts.chk_done) begin
          state_nxt = S_DIVIDE;
        end else begin
          cmd.chk_step = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.quo_zero) begin
          state_nxt = sts.neg ? S_SIGN : S_READ;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = sts.cnt_zero ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/srde_dp.sv */
// ---------------------------------------------------------------------------
// srde_dp
// config registers, alphabet checker, radix divider, digit stack, output reg
// ---------------------------------------------------------------------------
module srde_dp import srde_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_W-1:0]       in_value,
  input  srde_cmd_t             cmd,
  output srde_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  is_last
);

  localparam int MW    = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int NSTEP = MW / 8;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int IW    = $clog2(VALUE_WIDTH);
  localparam int CW    = $clog2(VALUE_WIDTH + 1);

  logic [BASE_W-1:0]    base_r;
  logic [ALPHA_W-1:0]   alpha_lo_r;
  logic [ALPHA_W-1:0]   alpha_hi_r;
  logic [2*ALPHA_W-1:0] alpha;

  logic                 neg_r;
  logic [MW-1:0]        quo_r;
  logic [BASE_W-1:0]    rem_r;
  logic [SW-1:0]        step_r;
  logic [CW-1:0]        cnt_r;
  logic [SYM_IDX_W-1:0] chk_i_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [VALUE_WIDTH-1:0] val;
  logic                   val_neg;
  logic [VALUE_WIDTH-1:0] val_mag;
  logic [MW-1:0]          div_quo;
  logic [BASE_W-1:0]      div_rem;
  logic                   div_last;
  logic [CW-1:0]          cnt_m1;
  logic [CHAR_W-1:0]      sym_i;
  logic                   dup;
  logic [SYM_IDX_W-1:0]   ram_rdata;
  logic                   out_load;

  assign alpha = {alpha_hi_r, alpha_lo_r};

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE_SIZE:  base_r     <= cfg_wdata[BASE_W-1:0];
        CFG_ALPHA_LOW:  alpha_lo_r <= cfg_wdata;
        CFG_ALPHA_HIGH: alpha_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sign and magnitude
  assign val     = in_value[VALUE_WIDTH-1:0];
  assign val_neg = val[VALUE_WIDTH-1];
  assign val_mag = val_neg ? (~val + 1'b1) : val;

  // alphabet check, one symbol per cycle against all later ones
  assign sym_i = sym_at(alpha, chk_i_r);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < NUM_SYMS; j++) begin
      if ((BASE_W'(j) > {1'b0, chk_i_r}) && (BASE_W'(j) < base_r) &&
          (sym_at(alpha, SYM_IDX_W'(j)) == sym_i)) begin
        dup = 1'b1;
      end
    end
  end

  assign sts.chk_fail = (base_r < BASE_W'(2)) || (base_r > BASE_W'(MAX_SYMBOLS)) ||
                        (sym_i == CHAR_PLUS) || (sym_i == CHAR_MINUS) || dup;
  assign sts.chk_done = ({1'b0, chk_i_r} == (base_r - BASE_W'(1)));

  // restoring division, eight quotient bits per cycle
  always_comb begin
    div_rem = rem_r;
    div_quo = quo_r;
    for (int k = 0; k < 8; k++) begin
      div_rem = {div_rem[BASE_W-2:0], div_quo[MW-1]};
      div_quo = {div_quo[MW-2:0], 1'b0};
      if (div_rem >= base_r) begin
        div_rem    = div_rem - base_r;
        div_quo[0] = 1'b1;
      end
    end
  end

  assign div_last     = (step_r == SW'(NSTEP - 1));
  assign sts.div_last = div_last;
  assign sts.quo_zero = (div_quo == '0);
  assign sts.neg      = neg_r;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;
  assign cnt_m1       = cnt_r - CW'(1);

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      cnt_r   <= '0;
      chk_i_r <= '0;
    end else begin
      if (cmd.load) begin
        step_r  <= '0;
        cnt_r   <= '0;
        chk_i_r <= '0;
      end
      if (cmd.chk_step) begin
        chk_i_r <= chk_i_r + SYM_IDX_W'(1);
      end
      if (cmd.div_step) begin
        if (div_last) begin
          step_r <= '0;
          cnt_r  <= cnt_r + CW'(1);
        end else begin
          step_r <= step_r + SW'(1);
        end
      end
      if (cmd.rd) begin
        cnt_r <= cnt_m1;
      end
    end
  end

  // value datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= val_neg;
      quo_r <= MW'(val_mag);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= div_quo;
      rem_r <= div_last ? '0 : div_rem;
    end
  end

  // digit stack, least significant first
  srde_ram #(
    .WIDTH (SYM_IDX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.div_step && div_last),
    .waddr (cnt_r[IW-1:0]),
    .wdata (div_rem[SYM_IDX_W-1:0]),
    .re    (cmd.rd),
    .raddr (cnt_m1[IW-1:0]),
    .rdata (ram_rdata)
  );

  // output register
  assign out_load = cmd.emit_sign || cmd.emit_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= sym_at(alpha, ram_rdata);
      out_last_r <= (cnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign is_last   = out_last_r;

endmodule

/* sv/signed_radix_digit_emitter_core.sv */
// ---------------------------------------------------------------------------
// signed_radix_digit_emitter_core
// signed integer to text in a configurable radix of up to 16 symbols
// ---------------------------------------------------------------------------
// One value is converted at a time. After acceptance the alphabet is checked
// at one symbol per cycle (a rejected alphabet ends the transaction there
// with no characters). Each digit then takes a pass of the shared divider,
// which retires eight quotient bits per cycle. Digits are pushed onto a
// stack RAM and popped most significant first; each character is a RAM read
// followed by an output load, and a leading '-' is loaded before the digits.
// The final character of a value has is_last. Configuration is to be
// written only while the block is idle; the block itself does not enforce
// this.
module signed_radix_digit_emitter_core import srde_pkg::*; #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  srde_in_if.sink               in_ch,
  srde_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  srde_cmd_t cmd;
  srde_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  srde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srde_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .is_last   (out_ch.is_last)
  );

endmodule

/* sv/srde_checker.sv */
// ---------------------------------------------------------------------------
// srde_checker
// port-level assertions for the signed radix digit emitter
// ---------------------------------------------------------------------------
`include "signed_radix_digit_emitter_core_macros.svh"

module srde_checker import srde_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              is_last
);

  // stalled output transaction holds
  `SRDE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(is_last))

  // one value at a time
  `SRDE_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // sign is never the final character
  `SRDE_ASSERT_IMP(a_sign_not_last, clk, rst_n, out_valid && (out_char == CHAR_MINUS), !is_last)

endmodule

bind signed_radix_digit_emitter_core srde_checker u_srde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .is_last   (out_ch.is_last)
);
